FILE: hdl/chte_pkg.sv
// Shared types and constants for the chained hash table engine.
package chte_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned OutIdxW = 10;
  localparam int unsigned LimitW = 11;
  localparam logic [LimitW-1:0] LoadLimitReset = 11'd972;

  typedef enum logic [1:0] {
    ACT_INSERT      = 2'd0,
    ACT_INSERT_SLOT = 2'd1,
    ACT_SEARCH      = 2'd2,
    ACT_DELETE      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]             action;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [ValW-1:0]  found_value;
    logic [OutIdxW-1:0]      slot;
    logic [OutIdxW-1:0]      bucket;
  } rsp_t;

endpackage

FILE: hdl/chained_hash_table_engine_core.sv
// Chained hash table engine: bucket heads, entry keys/values/links in RAM.
// After reset a clearing pass empties the buckets and builds the free list; no
// request is taken until it ends (config is). A search reads the bucket head, then
// walks the chain one node at a time (single read port of the entry memories); a
// delete does the same, then unlinks the hit at the chain head, or further down
// via its predecessor and then frees it. An insert reads the next free entry first.
// One request at a time. Result is held in an output register until taken.
module chained_hash_table_engine_core #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  chte_pkg::req_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output chte_pkg::rsp_t              out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [chte_pkg::LimitW-1:0] cfg_data_i
);

  localparam int unsigned IdxW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned LinkW = IdxW + 1;
  localparam int unsigned CntW  = IdxW + 1;
  localparam logic [LinkW-1:0] LinkEnd = LinkW'(TABLE_ENTRIES);
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_HEAD   = 11'b00000000100,
    S_HWAIT  = 11'b00000001000,
    S_NODE   = 11'b00000010000,
    S_NWAIT  = 11'b00000100000,
    S_INSRD  = 11'b00001000000,
    S_INSWT  = 11'b00010000000,
    S_UNLINK = 11'b00100000000,
    S_FREE   = 11'b01000000000,
    S_RESP   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [IdxW-1:0]   clr_q, clr_d;
  logic [LinkW-1:0]  free_q, free_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [chte_pkg::LimitW-1:0] limit_q;
  chte_pkg::req_t    req_q, req_d;
  chte_pkg::rsp_t    rsp_q, rsp_d;
  logic [LinkW-1:0]  cur_q, cur_d, prev_q, prev_d;

  // memory ports
  logic             hd_we, lk_we, kv_we;
  logic [IdxW-1:0]  hd_wa, hd_ra, lk_wa, lk_ra, kv_wa, kv_ra;
  logic [LinkW-1:0] hd_wd, hd_rd, lk_wd, lk_rd;
  logic [chte_pkg::KeyW+chte_pkg::ValW-1:0] kv_wd, kv_rd;

  logic [IdxW-1:0] bkt;
  assign bkt = req_q.key[IdxW-1:0];

  chte_ram #(.Width(LinkW), .Depth(TABLE_ENTRIES)) u_heads (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(hd_ra),
    .rdata_o(hd_rd));
  chte_ram #(.Width(LinkW), .Depth(TABLE_ENTRIES)) u_links (
    .clk_i, .we_i(lk_we), .waddr_i(lk_wa), .wdata_i(lk_wd), .raddr_i(lk_ra),
    .rdata_o(lk_rd));
  chte_ram #(.Width(chte_pkg::KeyW + chte_pkg::ValW), .Depth(TABLE_ENTRIES)) u_kv (
    .clk_i, .we_i(kv_we), .waddr_i(kv_wa), .wdata_i(kv_wd), .raddr_i(kv_ra),
    .rdata_o(kv_rd));

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign out_data_o  = rsp_q;
  assign cfg_ready_o = 1'b1;

  logic ins_full;
  assign ins_full = ({1'b0, count_q} + (CntW+1)'(1) >= (CntW+1)'(limit_q))
                    || (count_q >= CntW'(TABLE_ENTRIES)) || free_q[IdxW];

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    free_d  = free_q;
    count_d = count_q;
    req_d   = req_q;
    rsp_d   = rsp_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    hd_we = 1'b0; hd_wa = bkt; hd_wd = LinkEnd; hd_ra = bkt;
    lk_we = 1'b0; lk_wa = clr_q; lk_wd = LinkEnd; lk_ra = cur_q[IdxW-1:0];
    kv_we = 1'b0; kv_wa = free_q[IdxW-1:0]; kv_ra = cur_q[IdxW-1:0];
    kv_wd = {req_q.key, req_q.value};
    unique case (state_q)
      S_CLEAR: begin
        hd_we = 1'b1; hd_wa = clr_q; hd_wd = LinkEnd;
        lk_we = 1'b1; lk_wa = clr_q;
        lk_wd = (clr_q == LastIdx) ? LinkEnd : {1'b0, clr_q} + LinkW'(1);
        clr_d = clr_q + IdxW'(1);
        if (clr_q == LastIdx) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        rsp_d.status      = chte_pkg::ST_OK;
        rsp_d.found_value = '0;
        rsp_d.slot        = '0;
        rsp_d.bucket      = chte_pkg::OutIdxW'(bkt);
        prev_d = LinkEnd;
        if (req_q.action == chte_pkg::ACT_INSERT ||
            req_q.action == chte_pkg::ACT_INSERT_SLOT) begin
          if (ins_full) begin
            rsp_d.status = chte_pkg::ST_FULL;
            state_d = S_RESP;
          end else begin
            lk_ra = free_q[IdxW-1:0];  // next free
            state_d = S_INSRD;
          end
        end else if (req_q.action == chte_pkg::ACT_SEARCH && count_q == '0) begin
          rsp_d.status = chte_pkg::ST_MISS;
          state_d = S_RESP;
        end else begin
          state_d = S_HWAIT;
        end
      end
      S_HWAIT: begin
        // head read data now valid
        cur_d = hd_rd;
        if (hd_rd[IdxW]) begin
          rsp_d.status = chte_pkg::ST_MISS;
          state_d = S_RESP;
        end else begin
          state_d = S_NODE;
        end
      end
      S_NODE: begin
        // reads of key/value and link at cur issued by default addresses
        state_d = S_NWAIT;
      end
      S_NWAIT: begin
        if (kv_rd[chte_pkg::KeyW+chte_pkg::ValW-1:chte_pkg::ValW] == req_q.key) begin
          rsp_d.slot = chte_pkg::OutIdxW'(cur_q[IdxW-1:0]);
          if (req_q.action == chte_pkg::ACT_SEARCH) begin
            rsp_d.found_value = kv_rd[chte_pkg::ValW-1:0];
            state_d = S_RESP;
          end else begin
            state_d = S_UNLINK;
          end
        end else if (lk_rd[IdxW]) begin
          rsp_d.status = chte_pkg::ST_MISS;
          state_d = S_RESP;
        end else begin
          prev_d = cur_q;
          cur_d  = lk_rd;
          state_d = S_NODE;
        end
      end
      S_UNLINK: begin
        // lk_rd still holds link of hit (read address unchanged)
        lk_we = 1'b1;
        if (prev_q[IdxW]) begin
          hd_we = 1'b1; hd_wd = lk_rd;
          lk_wa = cur_q[IdxW-1:0]; lk_wd = free_q;
          free_d = cur_q;
          if (count_q != '0) count_d = count_q - CntW'(1);
          state_d = S_RESP;
        end else begin
          lk_wa = prev_q[IdxW-1:0]; lk_wd = lk_rd;
          state_d = S_FREE;
        end
      end
      S_FREE: begin
        // hit link now points at the old free head
        lk_we = 1'b1; lk_wa = cur_q[IdxW-1:0]; lk_wd = free_q;
        free_d = cur_q;
        if (count_q != '0) count_d = count_q - CntW'(1);
        state_d = S_RESP;
      end
      S_INSRD: begin
        lk_ra = free_q[IdxW-1:0];
        state_d = S_INSWT;
      end
      S_INSWT: begin
        // lk_rd = next free, hd_rd = current bucket head
        kv_we = 1'b1;
        if (req_q.action == chte_pkg::ACT_INSERT_SLOT)
          kv_wd = {req_q.key, chte_pkg::ValW'(free_q[IdxW-1:0])};
        lk_we = 1'b1; lk_wa = free_q[IdxW-1:0]; lk_wd = hd_rd;
        hd_we = 1'b1; hd_wd = free_q;
        rsp_d.slot = chte_pkg::OutIdxW'(free_q[IdxW-1:0]);
        free_d  = lk_rd;
        count_d = count_q + CntW'(1);
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      free_q  <= '0;
      count_q <= '0;
      limit_q <= chte_pkg::LoadLimitReset;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      free_q  <= free_d;
      count_q <= count_d;
      if (cfg_valid_i) limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rsp_q  <= rsp_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_ENTRIES)) else $error("entry count overflow");
  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(rsp_q)) else $error("result changed");
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o) else $error("accept during clear");
  a_full_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HEAD && ins_full && req_q.action[1] == 1'b0 |=> $stable(count_q))
    else $error("full insert changed count");

endmodule

FILE: hdl/chte_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module chte_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: tb/chte_scoreboard.sv
// Response checker for the chained hash table engine: predicts and compares results.
`timescale 1ns / 100ps

module chte_scoreboard #(
  parameter int unsigned TABLE_ENTRIES = 1024
) (
  input  logic                          clk_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  chte_pkg::req_t                in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  chte_pkg::rsp_t                out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [chte_pkg::LimitW-1:0]   cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_count_o
);

  localparam int unsigned LinkEnd = TABLE_ENTRIES;

  // predicted table contents
  logic [10:0]                 head_mem [TABLE_ENTRIES];
  logic [chte_pkg::KeyW-1:0]   key_mem  [TABLE_ENTRIES];
  logic [chte_pkg::ValW-1:0]   val_mem  [TABLE_ENTRIES];
  logic [10:0]                 next_mem [TABLE_ENTRIES];
  logic [10:0]                 free_slot;
  logic [10:0]                 used_count;
  logic [chte_pkg::LimitW-1:0] limit_q;
  chte_pkg::rsp_t              expected_rsp_q [$];
  int                          fails;
  int                          pending;

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      head_mem[i] = 11'(LinkEnd);
      key_mem[i]  = '0;
      val_mem[i]  = '0;
      next_mem[i] = 11'(i + 1);
    end
    free_slot  = '0;
    used_count = '0;
    limit_q    = chte_pkg::LoadLimitReset;
    fails      = 0;
    pending    = 0;
  end

  // newest entry with the key in a bucket; prev gets LinkEnd at the chain head
  function automatic logic [10:0] chain_lookup(input logic [9:0] b,
                                               input logic [chte_pkg::KeyW-1:0] k,
                                               output logic [10:0] prev);
    logic [10:0] cur;
    logic [10:0] back;
    cur  = head_mem[b];
    back = 11'(LinkEnd);
    prev = 11'(LinkEnd);
    for (int g = 0; g < TABLE_ENTRIES && cur < LinkEnd; g++) begin
      if (key_mem[cur] == k) begin
        prev = back;
        return cur;
      end
      back = cur;
      cur  = next_mem[cur];
    end
    return 11'(LinkEnd);
  endfunction

  function automatic chte_pkg::rsp_t apply_request(input chte_pkg::req_t rq);
    chte_pkg::rsp_t r;
    logic [9:0]  b;
    logic [10:0] hit;
    logic [10:0] prev;
    logic [10:0] s;
    b = rq.key[9:0];
    r = '0;
    r.status = chte_pkg::ST_OK;
    r.bucket = b;
    case (chte_pkg::action_e'(rq.action))
      chte_pkg::ACT_INSERT, chte_pkg::ACT_INSERT_SLOT: begin
        if (used_count + 11'd1 >= limit_q || used_count >= TABLE_ENTRIES ||
            free_slot >= LinkEnd) begin
          r.status = chte_pkg::ST_FULL;
        end else begin
          s = free_slot;
          free_slot = next_mem[s];
          key_mem[s] = rq.key;
          val_mem[s] = (chte_pkg::action_e'(rq.action) == chte_pkg::ACT_INSERT) ?
                       rq.value : chte_pkg::ValW'(s);
          next_mem[s] = head_mem[b];
          head_mem[b] = s;
          used_count++;
          r.slot = s[9:0];
        end
      end
      chte_pkg::ACT_SEARCH: begin
        hit = (used_count == 0) ? 11'(LinkEnd) : chain_lookup(b, rq.key, prev);
        if (hit < LinkEnd) begin
          r.found_value = val_mem[hit];
          r.slot = hit[9:0];
        end else begin
          r.status = chte_pkg::ST_MISS;
        end
      end
      default: begin
        hit = chain_lookup(b, rq.key, prev);
        if (hit < LinkEnd) begin
          if (prev < LinkEnd) next_mem[prev] = next_mem[hit];
          else head_mem[b] = next_mem[hit];
          next_mem[hit] = free_slot;
          free_slot = hit;
          if (used_count > 0) used_count--;
          r.slot = hit[9:0];
        end else begin
          r.status = chte_pkg::ST_MISS;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    chte_pkg::rsp_t exp_rsp;
    if (cfg_valid_i && cfg_ready_i) limit_q = cfg_data_i;
    if (out_valid_i && out_ready_i) begin
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected result: %p", out_data_i);
        fails++;
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (out_data_i.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, out_data_i.status);
          fails++;
        end
        if (out_data_i.found_value !== exp_rsp.found_value) begin
          $error("found_value: expected %0d, got %0d", exp_rsp.found_value,
                 out_data_i.found_value);
          fails++;
        end
        if (out_data_i.slot !== exp_rsp.slot) begin
          $error("slot: expected %0d, got %0d", exp_rsp.slot, out_data_i.slot);
          fails++;
        end
        if (out_data_i.bucket !== exp_rsp.bucket) begin
          $error("bucket: expected %0d, got %0d", exp_rsp.bucket, out_data_i.bucket);
          fails++;
        end
      end
    end
    if (in_valid_i && in_ready_i) expected_rsp_q.push_back(apply_request(in_data_i));
    pending = expected_rsp_q.size();
  end

  assign fail_count_o    = fails;
  assign pending_count_o = pending;

endmodule

FILE: tb/chained_hash_table_engine_core_test.sv
// Testbench top for the chained hash table engine: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module chained_hash_table_engine_core_test;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  chte_pkg::req_t              in_data_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  chte_pkg::rsp_t              out_data_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [chte_pkg::LimitW-1:0] cfg_data_i = '0;
  int                          fail_count;
  int                          pending_count;
  logic                        in_fire_q = 1'b0;
  logic                        out_fire_q = 1'b0;
  logic                        cfg_fire_q = 1'b0;
  bit                          no_gaps = 1'b0;
  logic [chte_pkg::KeyW-1:0]   key_pool [48];

  always #2 clk_i = ~clk_i;

  chained_hash_table_engine_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o, .out_ready_i,
    .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  chte_scoreboard u_scoreboard (
    .clk_i, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i, .out_valid_i(out_valid_o),
    .out_ready_i, .out_data_i(out_data_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_data_i, .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  always @(posedge clk_i) begin
    in_fire_q  <= in_valid_i && in_ready_o;
    out_fire_q <= out_valid_o && out_ready_i;
    cfg_fire_q <= cfg_valid_i && cfg_ready_o;
  end

  // result side stalls
  initial begin
    int stall;
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(negedge clk_i); while (!out_fire_q);
    end
  end

  task automatic send_request(input chte_pkg::action_e act,
                              input logic [chte_pkg::KeyW-1:0] k,
                              input logic [chte_pkg::ValW-1:0] v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i.action = act;
    in_data_i.key    = k;
    in_data_i.value  = v;
    in_valid_i = 1'b1;
    do @(negedge clk_i); while (!in_fire_q);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [chte_pkg::LimitW-1:0] lim);
    drain_results();
    cfg_data_i  = lim;
    cfg_valid_i = 1'b1;
    do @(negedge clk_i); while (!cfg_fire_q);
    cfg_valid_i = 1'b0;
  endtask

  // mixed random traffic; keys mostly from a pool so hits and chains build up
  task automatic random_traffic(input int count, input int ins_pct, input int del_pct);
    int                        roll;
    chte_pkg::action_e         act;
    logic [chte_pkg::KeyW-1:0] k;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct)
        act = ($urandom_range(0, 3) == 0) ? chte_pkg::ACT_INSERT_SLOT : chte_pkg::ACT_INSERT;
      else if (roll < ins_pct + del_pct) act = chte_pkg::ACT_DELETE;
      else act = chte_pkg::ACT_SEARCH;
      k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 47)] : $urandom;
      send_request(act, k, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = {22'($urandom), 10'd5};
    key_pool[8]  = 32'h8000_0000;
    key_pool[9]  = 32'h7FFF_FFFF;
    key_pool[10] = 32'h0;
    key_pool[11] = 32'hFFFF_FFFF;
    for (int i = 12; i < 48; i++) key_pool[i] = $urandom;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, extremes, collisions, newest-first order
    send_request(chte_pkg::ACT_SEARCH, 32'h0, 32'h0);
    send_request(chte_pkg::ACT_DELETE, 32'h7FFF_FFFF, 32'h0);
    send_request(chte_pkg::ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(chte_pkg::ACT_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(chte_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(chte_pkg::ACT_INSERT_SLOT, 32'h0, 32'h1234_5678);
    send_request(chte_pkg::ACT_SEARCH, 32'h8000_0000, 32'h0);
    send_request(chte_pkg::ACT_SEARCH, 32'h7FFF_FFFF, 32'h0);
    send_request(chte_pkg::ACT_SEARCH, 32'hFFFF_FFFF, 32'h0);
    send_request(chte_pkg::ACT_SEARCH, 32'h0, 32'h0);
    send_request(chte_pkg::ACT_INSERT, key_pool[0], 32'h1);
    send_request(chte_pkg::ACT_INSERT, key_pool[1], 32'h2);
    send_request(chte_pkg::ACT_INSERT, key_pool[0], 32'h3);
    send_request(chte_pkg::ACT_SEARCH, key_pool[0], 32'h0);
    send_request(chte_pkg::ACT_SEARCH, key_pool[2], 32'h0);
    send_request(chte_pkg::ACT_DELETE, key_pool[0], 32'h0);
    send_request(chte_pkg::ACT_SEARCH, key_pool[0], 32'h0);
    send_request(chte_pkg::ACT_DELETE, key_pool[1], 32'h0);
    send_request(chte_pkg::ACT_DELETE, key_pool[3], 32'h0);
    send_request(chte_pkg::ACT_INSERT, key_pool[4], 32'h5555_AAAA);
    send_request(chte_pkg::ACT_DELETE, 32'h0, 32'h0);

    write_limit(11'd0);
    random_traffic(12, 60, 20);
    write_limit(11'd1);
    random_traffic(12, 60, 20);
    write_limit(11'd4);
    random_traffic(150, 50, 25);
    no_gaps = 1'b1;
    write_limit(11'd1024);
    random_traffic(150, 70, 10);
    no_gaps = 1'b0;
    random_traffic(600, 75, 5);
    write_limit(11'd972);
    random_traffic(250, 15, 60);
    write_limit(11'd40);
    random_traffic(200, 40, 35);

    drain_results();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: files.f
hdl/chte_pkg.sv
hdl/chte_ram.sv
hdl/chained_hash_table_engine_core.sv
tb/chte_scoreboard.sv
tb/chained_hash_table_engine_core_test.sv
